// ----- rtl/mcc_pkg.sv -----
// Shared types, constants and functions of the mnemonic checksum codec.
// No dependencies; mcc_sha, mcc_ctrl, mcc_datapath and the top import this package.
package mcc_pkg;

	localparam int MCC_MAX_WORDS = 24;
	localparam int MCC_MIN_WORDS = 12;
	localparam int IDX_W = 11;
	localparam int WL_DEPTH = 2048;
	localparam int TEXT_W = 64;
	localparam int CNT_W = 5;
	localparam int GEN_WORDS = 12;
	localparam int GEN_BYTES = 16;
	localparam int BYTE_SAT = 31;
	localparam int VEC_MAX = 264;
	localparam int BLK_W = 512;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_CHECK = 2'd1;
	localparam logic [1:0] OP_GEN = 2'd2;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_UNKNOWN = 3'd1,
		ST_BAD_COUNT = 3'd2,
		ST_MISMATCH = 3'd3,
		ST_BAD_LEN = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SRCH_ADDR,
		S_SRCH_CMP,
		S_AFTER,
		S_VERD,
		S_CHK_SHA,
		S_EMIT_V,
		S_GEN_CHK,
		S_GEN_ERR,
		S_GEN_SHA,
		S_GEN_RD,
		S_GEN_OUT
	} state_t;

	typedef struct packed {
		logic load_wr;
		logic accept;
		logic take_word;
		logic set_ovf;
		logic take_byte;
		logic probe;
		logic narrow;
		logic store_idx;
		logic set_unk;
		logic sha_chk;
		logic sha_gen;
		logic gen_load;
		logic gen_rd;
		logic emit_verdict;
		logic emit_err;
		logic emit_word;
		logic clr_check;
		logic clr_gen;
	} cmd_t;

	typedef struct packed {
		logic can_search;
		logic at_max;
		logic range_open;
		logic hit;
		logic last;
		logic need_sha;
		logic sha_done;
		logic out_free;
		logic gen_final;
		logic len_ok;
	} sts_t;

	function automatic logic [31:0] sha_iv(input logic [2:0] i);
		logic [31:0] r;
		case (i)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			default: r = 32'h5be0cd19;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] sha_k(input logic [5:0] i);
		logic [31:0] r;
		case (i)
			6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;
			6'd2: r = 32'hb5c0fbcf;  6'd3: r = 32'he9b5dba5;
			6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
			6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;
			6'd8: r = 32'hd807aa98;  6'd9: r = 32'h12835b01;
			6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
			6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
			6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
			6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
			6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
			6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
			6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
			6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
			6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
			6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
			6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
			6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
			6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
			6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
			6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
			6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
			6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
			6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
			6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
			6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
			6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
			6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
			6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
			6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
			6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
			6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
			6'd62: r = 32'hbef9a3f7; default: r = 32'hc67178f2;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/mcc_if.sv -----
// Channel interfaces of the mnemonic checksum codec: input beats and result beats.
// No dependencies.
interface mcc_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [63:0] word_text;
	logic [10:0] entry_index;
	logic [7:0]  entropy_byte;
	logic        last;

	modport source (output valid, op, word_text, entry_index, entropy_byte, last,
		input ready);
	modport sink (input valid, op, word_text, entry_index, entropy_byte, last,
		output ready);
endinterface

interface mcc_out_if;
	logic        valid;
	logic        ready;
	logic        valid_res;
	logic [2:0]  status;
	logic [10:0] word_index;
	logic [63:0] word_out;
	logic        last_of_run;

	modport source (output valid, valid_res, status, word_index, word_out, last_of_run,
		input ready);
	modport sink (input valid, valid_res, status, word_index, word_out, last_of_run,
		output ready);
endinterface

// ----- rtl/mcc_sha.sv -----
// Single-block SHA-256 engine, one round per clock; returns the top digest byte.
// Depends on mcc_pkg for the round constants and initial hash values.
module mcc_sha
	import mcc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [BLK_W-1:0] blk,
	output logic             done,
	output logic [7:0]       h0
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  rnd_q;
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [7:0]  h0_q;

	logic [31:0] s1_e, ch, t1, s0_a, mj, t2, ws0, ws1, w_new, a_new;

	always_comb begin
		s1_e = {v_q[4][5:0], v_q[4][31:6]} ^ {v_q[4][10:0], v_q[4][31:11]}
			^ {v_q[4][24:0], v_q[4][31:25]};
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1 = v_q[7] + s1_e + ch + sha_k(rnd_q) + w_q[0];
		s0_a = {v_q[0][1:0], v_q[0][31:2]} ^ {v_q[0][12:0], v_q[0][31:13]}
			^ {v_q[0][21:0], v_q[0][31:22]};
		mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2 = s0_a + mj;
		a_new = t1 + t2;
		ws0 = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]} ^ (w_q[1] >> 3);
		ws1 = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
			^ (w_q[14] >> 10);
		w_new = w_q[0] + ws0 + w_q[9] + ws1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				rnd_q <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= blk[BLK_W-1-32*i -: 32];
			end
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= sha_iv(3'(i));
			end
		end else if (busy_q) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= a_new;
			if (rnd_q == 6'd63) begin
				h0_q <= 8'((a_new + sha_iv(3'd0)) >> 24);
			end
		end
	end

	assign done = done_q;
	assign h0 = h0_q;

endmodule

// ----- rtl/mcc_ctrl.sv -----
// Sequencing state machine of the mnemonic checksum codec.
// Depends on mcc_pkg for the state, command and status types.
module mcc_ctrl
	import mcc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_op,
	input  logic       in_last,
	output logic       in_ready,
	input  sts_t       sts,
	output cmd_t       cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (in_op == OP_CHECK) begin
						if (sts.can_search) state_d = S_SRCH_ADDR;
						else if (in_last) state_d = S_VERD;
					end else if (in_op == OP_GEN && in_last) begin
						state_d = S_GEN_CHK;
					end
				end
			end
			S_SRCH_ADDR: state_d = sts.range_open ? S_SRCH_CMP : S_AFTER;
			S_SRCH_CMP: state_d = sts.hit ? S_AFTER : S_SRCH_ADDR;
			S_AFTER: state_d = sts.last ? S_VERD : S_IDLE;
			S_VERD: state_d = sts.need_sha ? S_CHK_SHA : S_EMIT_V;
			S_CHK_SHA: if (sts.sha_done) state_d = S_EMIT_V;
			S_EMIT_V: if (sts.out_free) state_d = S_IDLE;
			S_GEN_CHK: state_d = sts.len_ok ? S_GEN_SHA : S_GEN_ERR;
			S_GEN_ERR: if (sts.out_free) state_d = S_IDLE;
			S_GEN_SHA: if (sts.sha_done) state_d = S_GEN_RD;
			S_GEN_RD: state_d = S_GEN_OUT;
			S_GEN_OUT: begin
				if (sts.out_free) state_d = sts.gen_final ? S_IDLE : S_GEN_RD;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (in_op == OP_LOAD) begin
						cmd.load_wr = 1'b1;
					end else if (in_op == OP_CHECK) begin
						cmd.take_word = sts.can_search;
						cmd.set_ovf = sts.at_max;
					end else if (in_op == OP_GEN) begin
						cmd.take_byte = 1'b1;
					end
				end
			end
			S_SRCH_ADDR: begin
				cmd.probe = sts.range_open;
				cmd.set_unk = !sts.range_open;
			end
			S_SRCH_CMP: begin
				cmd.store_idx = sts.hit;
				cmd.narrow = !sts.hit;
			end
			S_VERD: cmd.sha_chk = sts.need_sha;
			S_EMIT_V: begin
				cmd.emit_verdict = sts.out_free;
				cmd.clr_check = sts.out_free;
			end
			S_GEN_CHK: begin
				cmd.clr_gen = 1'b1;
				cmd.sha_gen = sts.len_ok;
			end
			S_GEN_ERR: cmd.emit_err = sts.out_free;
			S_GEN_SHA: cmd.gen_load = sts.sha_done;
			S_GEN_RD: cmd.gen_rd = 1'b1;
			S_GEN_OUT: cmd.emit_word = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// ----- rtl/mcc_datapath.sv -----
// Datapath of the mnemonic checksum codec: wordlist memory, search bounds,
// index and entropy buffers, SHA-256 message setup and the result register.
// Depends on mcc_pkg and instantiates mcc_sha.
module mcc_datapath
	import mcc_pkg::*;
#(
	parameter int MAX_WORDS = MCC_MAX_WORDS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic [TEXT_W-1:0] in_text,
	input  logic [IDX_W-1:0]  in_entry,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	input  logic              out_ready,
	output logic              out_valid,
	output logic              out_valid_res,
	output logic [2:0]        out_status,
	output logic [IDX_W-1:0]  out_word_index,
	output logic [TEXT_W-1:0] out_word_out,
	output logic              out_last_of_run
);

	localparam int VW = IDX_W * MAX_WORDS;
	localparam int GEN_W = GEN_BYTES * 8 + 4;

	logic [TEXT_W-1:0] mem [WL_DEPTH];
	logic [TEXT_W-1:0] rdata_q;
	logic [IDX_W-1:0]  raddr;

	logic [TEXT_W-1:0] text_q;
	logic [IDX_W:0]    lo_q, hx_q;
	logic [IDX_W-1:0]  mid, mid_q;
	logic              last_q;

	logic [VW-1:0]     vec_q;
	logic [CNT_W-1:0]  wc_q;
	logic              unk_q;
	logic [GEN_BYTES*8-1:0] ent_q;
	logic [CNT_W-1:0]  bc_q;

	logic [GEN_W-1:0]  gen_sr_q;
	logic [3:0]        gen_cnt_q;
	logic [IDX_W-1:0]  gen_idx_q;

	logic              out_valid_q, out_vres_q, out_last_q;
	logic [2:0]        out_status_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic [TEXT_W-1:0] out_word_q;

	logic              sha_start, sha_done;
	logic [7:0]        sha_h0;
	logic [BLK_W-1:0]  sha_blk, chk_blk, gen_blk;

	logic              cnt_ok;
	logic [8:0]        ent_bits, al_sh;
	logic [3:0]        cs_bits;
	logic [VEC_MAX-1:0] aligned, cs_view;
	logic [7:0]        cs_mask;
	logic              mismatch;
	status_t           verdict;

	// Midpoint of the open range [lo, hx).
	assign mid = IDX_W'((13'(lo_q) + 13'(hx_q) - 13'd1) >> 1);
	assign raddr = cmd.gen_rd ? gen_sr_q[GEN_W-1 -: IDX_W] : mid;

	always_ff @(posedge clk) begin
		if (cmd.load_wr) mem[in_entry] <= in_text;
		if (cmd.probe || cmd.gen_rd) rdata_q <= mem[raddr];
	end

	// Word-count dependent message layout; only legal counts reach the hash.
	always_comb begin
		cnt_ok = 1'b1;
		ent_bits = 9'd128;
		cs_bits = 4'd4;
		al_sh = 9'd132;
		case (wc_q)
			5'd12: begin ent_bits = 9'd128; cs_bits = 4'd4; al_sh = 9'd132; end
			5'd15: begin ent_bits = 9'd160; cs_bits = 4'd5; al_sh = 9'd99; end
			5'd18: begin ent_bits = 9'd192; cs_bits = 4'd6; al_sh = 9'd66; end
			5'd21: begin ent_bits = 9'd224; cs_bits = 4'd7; al_sh = 9'd33; end
			5'd24: begin ent_bits = 9'd256; cs_bits = 4'd8; al_sh = 9'd0; end
			default: cnt_ok = 1'b0;
		endcase
		if (32'(wc_q) > MAX_WORDS) cnt_ok = 1'b0;
		aligned = VEC_MAX'(vec_q) << al_sh;
		chk_blk = ({aligned, {(BLK_W-VEC_MAX){1'b0}}} & ~({BLK_W{1'b1}} >> ent_bits))
			| ({1'b1, {(BLK_W-1){1'b0}}} >> ent_bits) | BLK_W'(ent_bits);
		gen_blk = {ent_q, 1'b1, {(BLK_W-GEN_BYTES*8-65){1'b0}}, 64'd128};
		cs_view = aligned << ent_bits;
		cs_mask = 8'hFF << (4'd8 - cs_bits);
		mismatch = |((cs_view[VEC_MAX-1 -: 8] ^ sha_h0) & cs_mask);
		if (unk_q) verdict = ST_UNKNOWN;
		else if (!cnt_ok) verdict = ST_BAD_COUNT;
		else if (mismatch) verdict = ST_MISMATCH;
		else verdict = ST_OK;
	end

	assign sha_start = cmd.sha_chk || cmd.sha_gen;
	assign sha_blk = cmd.sha_gen ? gen_blk : chk_blk;

	mcc_sha u_sha (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sha_start),
		.blk   (sha_blk),
		.done  (sha_done),
		.h0    (sha_h0)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q <= '0;
			unk_q <= 1'b0;
			bc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.set_ovf) wc_q <= CNT_W'(MAX_WORDS + 1);
			if (cmd.store_idx) wc_q <= wc_q + 1'b1;
			if (cmd.set_unk) unk_q <= 1'b1;
			if (cmd.clr_check) begin
				wc_q <= '0;
				unk_q <= 1'b0;
			end
			if (cmd.take_byte) bc_q <= (bc_q == CNT_W'(BYTE_SAT)) ? bc_q : bc_q + 1'b1;
			if (cmd.clr_gen) bc_q <= '0;
			if (cmd.emit_verdict || cmd.emit_err || cmd.emit_word) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) last_q <= in_last;
		if (cmd.take_word) begin
			text_q <= in_text;
			lo_q <= '0;
			hx_q <= (IDX_W+1)'(WL_DEPTH);
		end
		if (cmd.probe) mid_q <= mid;
		if (cmd.narrow) begin
			if (text_q < rdata_q) hx_q <= {1'b0, mid_q};
			else lo_q <= {1'b0, mid_q} + 1'b1;
		end
		if (cmd.store_idx) vec_q <= {vec_q[VW-IDX_W-1:0], mid_q};
		if (cmd.take_byte && bc_q < CNT_W'(GEN_BYTES)) ent_q <= {ent_q[GEN_BYTES*8-9:0], in_byte};
		if (cmd.gen_load) begin
			gen_sr_q <= {ent_q, sha_h0[7:4]};
			gen_cnt_q <= '0;
		end
		if (cmd.gen_rd) gen_idx_q <= raddr;
		if (cmd.emit_word) begin
			gen_sr_q <= gen_sr_q << IDX_W;
			gen_cnt_q <= gen_cnt_q + 4'd1;
		end
		if (cmd.emit_verdict) begin
			out_vres_q <= (verdict == ST_OK);
			out_status_q <= verdict;
			out_idx_q <= '0;
			out_word_q <= '0;
			out_last_q <= 1'b1;
		end else if (cmd.emit_err) begin
			out_vres_q <= 1'b0;
			out_status_q <= ST_BAD_LEN;
			out_idx_q <= '0;
			out_word_q <= '0;
			out_last_q <= 1'b1;
		end else if (cmd.emit_word) begin
			out_vres_q <= 1'b1;
			out_status_q <= ST_OK;
			out_idx_q <= gen_idx_q;
			out_word_q <= rdata_q;
			out_last_q <= (gen_cnt_q == 4'(GEN_WORDS - 1));
		end
	end

	always_comb begin
		sts.can_search = !unk_q && (32'(wc_q) < MAX_WORDS);
		sts.at_max = !unk_q && (32'(wc_q) == MAX_WORDS);
		sts.range_open = lo_q < hx_q;
		sts.hit = (rdata_q == text_q);
		sts.last = last_q;
		sts.need_sha = !unk_q && cnt_ok;
		sts.sha_done = sha_done;
		sts.out_free = !out_valid_q || out_ready;
		sts.gen_final = (gen_cnt_q == 4'(GEN_WORDS - 1));
		sts.len_ok = (bc_q == CNT_W'(GEN_BYTES));
	end

	assign out_valid = out_valid_q;
	assign out_valid_res = out_vres_q;
	assign out_status = out_status_q;
	assign out_word_index = out_idx_q;
	assign out_word_out = out_word_q;
	assign out_last_of_run = out_last_q;

endmodule

// ----- rtl/mnemonic_checksum_codec_top.sv -----
// Top level of the mnemonic checksum codec.
// Depends on mcc_pkg, mcc_if, mcc_ctrl and mcc_datapath.
//
// Usage: the din channel carries one beat per item. A load beat writes a
// wordlist entry. A check beat binary-searches its word in the 2048-entry
// wordlist, each probe an address step, then a registered read and compare,
// so at most 12 probes per word. The beat marked last then yields one
// verdict on dout; when the word count is legal and no word was unknown, a
// 64-round SHA-256 pass (one round per cycle) comes first. Generate beats
// each collect one entropy byte; with exactly 16 bytes the last one starts
// the hash and then emits 12 result beats, each needing a wordlist read;
// otherwise it emits one bad-length beat.
// The block takes one item at a time: din.ready is high only while the
// sequencer is idle. A single output register holds each result beat; when
// the receiver stalls the sequencer waits with the next result, and the
// next input beat can be accepted while the final result still waits.
// Reset clears the sequencer, the word and byte counts and the output valid.
// The wordlist needs no clearing pass; entries must be loaded before use.
module mnemonic_checksum_codec_top
	import mcc_pkg::*;
#(
	parameter int MAX_WORDS = MCC_MAX_WORDS
) (
	input logic       clk,
	input logic       arst_n,
	mcc_in_if.sink    din,
	mcc_out_if.source dout
);

	cmd_t cmd;
	sts_t sts;

	// The sequencer sees only the handshake and routing fields of the beat.
	mcc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(din.valid),
		.in_op   (din.op),
		.in_last (din.last),
		.in_ready(din.ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	mcc_datapath #(
		.MAX_WORDS(MAX_WORDS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.in_text        (din.word_text),
		.in_entry       (din.entry_index),
		.in_byte        (din.entropy_byte),
		.in_last        (din.last),
		.out_ready      (dout.ready),
		.out_valid      (dout.valid),
		.out_valid_res  (dout.valid_res),
		.out_status     (dout.status),
		.out_word_index (dout.word_index),
		.out_word_out   (dout.word_out),
		.out_last_of_run(dout.last_of_run)
	);

endmodule
